// ===== rtl/assert_macros.svh =====
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// The condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("assertion failed: forbidden condition");

`endif

// ===== rtl/dtfd_pkg.sv =====
package dtfd_pkg;

    localparam int RAW_W      = 20;
    localparam int TAG_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int KIND_W     = 3;
    localparam int READING_W  = 26;
    localparam int POLE_W     = 6;
    localparam int SHIFTED_W  = 16;
    localparam int PERIOD_W   = 22;
    localparam int DIV_STEPS  = 13;
    localparam int STEP_CNT_W = 4;

    localparam logic [READING_W-1:0] RPM_NUMERATOR = 26'd60000000;
    localparam logic [POLE_W-1:0]    POLE_RESET    = 6'd7;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_RPM     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TEMP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VOLTAGE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CURRENT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OTHER   = 3'd4;

    localparam logic [3:0] TYPE_TEMP    = 4'h2;
    localparam logic [3:0] TYPE_VOLTAGE = 4'h4;
    localparam logic [3:0] TYPE_CURRENT = 4'h6;

    localparam logic [3:0] GCR_NIBBLE [32] = '{
        4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
        4'h0, 4'h9, 4'hA, 4'hB, 4'h0, 4'hD, 4'hE, 4'hF,
        4'h0, 4'h0, 4'h2, 4'h3, 4'h0, 4'h5, 4'h6, 4'h7,
        4'h0, 4'h0, 4'h8, 4'h1, 4'h0, 4'h4, 4'hC, 4'h0
    };

    typedef struct packed {
        logic [RAW_W-1:0] raw_frame;
        logic [TAG_W-1:0] motor_tag;
    } t_in;

    typedef struct packed {
        logic [TAG_W-1:0]     motor_out;
        logic [STATUS_W-1:0]  status;
        logic [KIND_W-1:0]    kind;
        logic [READING_W-1:0] reading;
    } t_out;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   kind;
        logic                needs_div;
        logic [PERIOD_W-1:0] value;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_back_state;

endpackage

// ===== rtl/dtfd_front.sv =====
module dtfd_front
    import dtfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_in               i_item,
    input  logic [POLE_W-1:0] i_pole_pairs,
    input  t_q_stat           i_q_stat,
    output logic              o_busy,
    output logic              o_push,
    output t_job              o_job
);

    logic r_valid;
    logic n_valid;
    t_in  r_item;

    logic                 accept;
    logic [RAW_W-1:0]     gcr;
    logic [15:0]          word;
    logic [3:0]           crc;
    logic [11:0]          payload;
    logic [3:0]           calc;
    logic [SHIFTED_W-1:0] shifted;
    logic [PERIOD_W-1:0]  period;

    assign o_busy = r_valid && i_q_stat.full;
    assign o_push = r_valid && !i_q_stat.full;
    assign accept = i_start && !o_busy;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        gcr = r_item.raw_frame ^ (r_item.raw_frame >> 1);
        for (int g = 0; g < 4; g++) begin
            word[g*4 +: 4] = GCR_NIBBLE[gcr[g*5 +: 5]];
        end
        crc     = word[3:0];
        payload = word[15:4];
        calc    = ~(payload[3:0] ^ payload[7:4] ^ payload[11:8]);
        shifted = {7'b0, payload[8:0]} << payload[11:9];
        period  = {6'b0, shifted} * {16'b0, i_pole_pairs};
    end

    always_comb begin
        o_job.tag       = r_item.motor_tag;
        o_job.status    = STATUS_OK;
        o_job.kind      = KIND_RPM;
        o_job.needs_div = 1'b0;
        o_job.value     = '0;
        if (crc != calc) begin
            o_job.status = STATUS_CHECKSUM;
        end else if (payload[8]) begin
            if (period == '0) begin
                o_job.status = STATUS_ZERO;
            end else begin
                o_job.needs_div = 1'b1;
                o_job.value     = period;
            end
        end else begin
            unique case (payload[11:8])
                TYPE_TEMP: begin
                    o_job.kind  = KIND_TEMP;
                    o_job.value = {14'b0, payload[7:0]};
                end
                TYPE_VOLTAGE: begin
                    o_job.kind  = KIND_VOLTAGE;
                    o_job.value = {14'b0, payload[7:0]};
                end
                TYPE_CURRENT: begin
                    o_job.kind  = KIND_CURRENT;
                    o_job.value = {14'b0, payload[7:0]};
                end
                default: begin
                    o_job.kind = KIND_OTHER;
                end
            endcase
        end
    end

endmodule

// ===== rtl/dtfd_queue.sv =====
module dtfd_queue
    import dtfd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/dtfd_back.sv =====
module dtfd_back
    import dtfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_job,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_result_valid,
    output t_out    o_result
);

    t_back_state r_state;
    t_back_state n_state;

    logic [STEP_CNT_W-1:0] r_cnt;
    logic [STEP_CNT_W-1:0] n_cnt;
    logic [PERIOD_W-1:0]   r_rem;
    logic [PERIOD_W-1:0]   n_rem;
    logic [PERIOD_W-1:0]   r_div;
    logic [PERIOD_W-1:0]   n_div;
    logic [READING_W-1:0]  r_num;
    logic [READING_W-1:0]  n_num;
    logic [READING_W-1:0]  r_quo;
    logic [READING_W-1:0]  n_quo;
    logic [TAG_W-1:0]      r_tag;
    logic [TAG_W-1:0]      n_tag;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out                  r_out;
    t_out                  n_out;

    logic [PERIOD_W:0]   rem_a;
    logic [PERIOD_W:0]   rem_b;
    logic [PERIOD_W:0]   red_a;
    logic [PERIOD_W:0]   red_b;
    logic                ge_a;
    logic                ge_b;
    logic                last_step;

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;
    assign last_step      = (r_cnt == STEP_CNT_W'(DIV_STEPS - 1));

    always_comb begin
        rem_a = {r_rem, r_num[READING_W-1]};
        ge_a  = (rem_a >= {1'b0, r_div});
        red_a = ge_a ? rem_a - {1'b0, r_div} : rem_a;
        rem_b = {red_a[PERIOD_W-1:0], r_num[READING_W-2]};
        ge_b  = (rem_b >= {1'b0, r_div});
        red_b = ge_b ? rem_b - {1'b0, r_div} : rem_b;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty && i_job.needs_div) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (last_step) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_div       = r_div;
        n_num       = r_num;
        n_quo       = r_quo;
        n_tag       = r_tag;
        n_out_valid = 1'b0;
        n_out       = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    if (i_job.needs_div) begin
                        n_cnt = '0;
                        n_rem = '0;
                        n_div = i_job.value;
                        n_num = RPM_NUMERATOR;
                        n_quo = '0;
                        n_tag = i_job.tag;
                    end else begin
                        n_out_valid       = 1'b1;
                        n_out.motor_out   = i_job.tag;
                        n_out.status      = i_job.status;
                        n_out.kind        = i_job.kind;
                        n_out.reading     = {{(READING_W - PERIOD_W){1'b0}}, i_job.value};
                    end
                end
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                n_rem = red_b[PERIOD_W-1:0];
                n_num = r_num << 2;
                n_quo = {r_quo[READING_W-3:0], ge_a, ge_b};
                if (last_step) begin
                    n_out_valid     = 1'b1;
                    n_out.motor_out = r_tag;
                    n_out.status    = STATUS_OK;
                    n_out.kind      = KIND_RPM;
                    n_out.reading   = n_quo;
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_div <= n_div;
        r_num <= n_num;
        r_quo <= n_quo;
        r_tag <= n_tag;
        r_out <= n_out;
    end

endmodule

// ===== rtl/dshot_telemetry_frame_decoder_unit.sv =====
// Decodes one captured telemetry frame per transaction into a tagged reading.
// A transaction is accepted at a rising edge with start high and busy low;
// i_item carries the 20-bit raw frame and the motor tag.
// Each result appears on o_result for exactly one cycle with o_result_valid
// high; the receiver cannot stall, so results are never held back.
// The user must write the pole pair register with i_cfg_we and i_cfg_wdata
// only while the block is idle; the block does not enforce this. It resets
// to seven. A front stage registers the frame, undoes the line coding, checks
// the checksum and forms the period with one small multiplier, then places a
// job in a queue of QUEUE_DEPTH entries.
// The back end emits sensor and error results one per cycle while no speed
// frame is being divided, each after the front register, the queue and the
// result register. Speed frames go through a divider that retires two
// quotient bits per cycle and takes no new job until the frame is through.
// Transactions are taken every cycle until the queue and the front stage fill,
// and busy is then raised.
// Reset empties the queue, idles the divider and drops any pending result.
`include "assert_macros.svh"

module dshot_telemetry_frame_decoder_unit
    import dtfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in               i_item,
    input  logic              i_cfg_we,
    input  logic [POLE_W-1:0] i_cfg_wdata,
    output logic              o_result_valid,
    output t_out              o_result
);

    logic [POLE_W-1:0] r_pole_pairs;
    logic              push;
    logic              pop;
    t_job              front_job;
    t_job              head_job;
    t_q_stat           q_stat;
    logic              error_result;
    logic              rpm_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_pairs <= POLE_RESET;
        end else if (i_cfg_we) begin
            r_pole_pairs <= i_cfg_wdata;
        end
    end

    dtfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (i_item),
        .i_pole_pairs (r_pole_pairs),
        .i_q_stat     (q_stat),
        .o_busy       (busy),
        .o_push       (push),
        .o_job        (front_job)
    );

    dtfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    dtfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    assign error_result = o_result_valid
                          && ((o_result.status != STATUS_OK) || (o_result.kind == KIND_OTHER));
    assign rpm_result   = o_result_valid
                          && (o_result.status == STATUS_OK) && (o_result.kind == KIND_RPM);

    `ASSERT_NEVER(a_queue_full_and_empty, i_clk, i_rst_n, q_stat.full && q_stat.empty)
    `ASSERT_IMPLY(a_pop_not_empty, i_clk, i_rst_n, pop, !q_stat.empty)
    `ASSERT_IMPLY(a_busy_needs_full, i_clk, i_rst_n, busy, q_stat.full)
    `ASSERT_IMPLY(a_error_reads_zero, i_clk, i_rst_n, error_result, o_result.reading == '0)
    `ASSERT_IMPLY(a_rpm_nonzero, i_clk, i_rst_n, rpm_result, o_result.reading != '0)

endmodule
